// ===== design/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants for the console line editor.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int unsigned CharW = 16;
  localparam int unsigned LenW  = 6;
  localparam int unsigned CfgW  = 7;

  localparam logic [CharW-1:0] KeyEnter     = 16'h000D;
  localparam logic [CharW-1:0] KeyBackspace = 16'h0008;
  localparam logic [CharW-1:0] KeySpace     = 16'h0020;
  localparam logic [CharW-1:0] PrintableMin = 16'h0020;

  localparam logic [CfgW-1:0] MaxLineLenReset = 7'd64;

  typedef enum logic [1:0] {
    KIND_ECHO      = 2'd0,
    KIND_LINE_CHAR = 2'd1,
    KIND_END       = 2'd2
  } cle_kind_e;

  typedef enum logic [1:0] {
    OP_PRINT = 2'd0,
    OP_BKSP  = 2'd1,
    OP_ENTER = 2'd2
  } cle_op_e;

  typedef struct packed {
    cle_op_e          op;
    logic [CharW-1:0] ch;
  } cle_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO,
    ST_BS1,
    ST_BS2,
    ST_BS3,
    ST_DRAIN_RD,
    ST_DRAIN_WR,
    ST_END
  } cle_state_e;

endpackage

// ===== design/console_line_editor.sv =====
// ----------------------------------------------------------------------------
// console_line_editor
// Line discipline with backspace echo over a valid/stall stream.
// ----------------------------------------------------------------------------
// Each input transfer is one 16-bit keystroke. Printable keys (0x20 and up)
// are stored and echoed while the line holds fewer than max_line_len-1
// characters (limit clamped to 0 .. LINE_CAP-1); backspace on a non-empty
// line removes the last character and echoes BS, SP, BS; enter streams out
// the stored line followed by an end marker carrying the length. Other
// control codes are swallowed. A classifier feeds a two-entry command
// queue, so keys are taken while the executor is busy. Enter drains each
// stored character by issuing a line buffer read (registered RAM output)
// and then loading the output register. The output register decouples the
// result stream, so downstream stall only delays results. max_line_len
// resets to 64 and is written through the cfg channel; the user must write
// it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module console_line_editor #(
  parameter int unsigned LINE_CAP = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // key input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cle_pkg::CharW-1:0]      key_char_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     kind_o,
  output logic [cle_pkg::CharW-1:0]      char_value_o,
  output logic [cle_pkg::LenW-1:0]       line_length_o,
  output logic                           last_o,
  // config write
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [cle_pkg::CfgW-1:0]       cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(LINE_CAP);

  logic [cle_pkg::CfgW-1:0] max_line_len_q;
  logic [cle_pkg::CfgW-1:0] len_m1;
  logic [cle_pkg::CfgW-1:0] limit_sat;
  logic [CntW-1:0]          limit;

  logic              cmd_valid;
  cle_pkg::cle_cmd_t cmd;
  logic              cmd_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_len_q <= cle_pkg::MaxLineLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_line_len_q <= cfg_wdata_i;
    end
  end

  // Character limit: max_line_len-1, clamped to 0 .. LINE_CAP-1.
  always_comb begin
    len_m1 = max_line_len_q - 1'b1;
    if (max_line_len_q == '0) begin
      limit_sat = '0;
    end else if (len_m1 > cle_pkg::CfgW'(LINE_CAP - 1)) begin
      limit_sat = cle_pkg::CfgW'(LINE_CAP - 1);
    end else begin
      limit_sat = len_m1;
    end
  end
  assign limit = limit_sat[CntW-1:0];

  cle_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .key_char_i  (key_char_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  cle_back #(
    .LINE_CAP (LINE_CAP)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .limit_i       (limit),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .char_value_o  (char_value_o),
    .line_length_o (line_length_o),
    .last_o        (last_o)
  );

endmodule

// ===== design/cle_ram.sv =====
// ----------------------------------------------------------------------------
// cle_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module cle_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cle_front.sv =====
// ----------------------------------------------------------------------------
// cle_front
// Key classifier and two-entry command queue.
// ----------------------------------------------------------------------------
module cle_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [cle_pkg::CharW-1:0]      key_char_i,
  output logic                           cmd_valid_o,
  output cle_pkg::cle_cmd_t              cmd_o,
  input  logic                           cmd_pop_i
);

  cle_pkg::cle_cmd_t cmd_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        fill_q, fill_d;
  logic              keep;
  logic              push;
  cle_pkg::cle_cmd_t new_cmd;

  // Classify: enter, backspace, printable; all other control codes drop.
  always_comb begin
    new_cmd.ch = key_char_i;
    new_cmd.op = cle_pkg::OP_PRINT;
    keep       = 1'b0;
    if (key_char_i == cle_pkg::KeyEnter) begin
      new_cmd.op = cle_pkg::OP_ENTER;
      keep       = 1'b1;
    end else if (key_char_i == cle_pkg::KeyBackspace) begin
      new_cmd.op = cle_pkg::OP_BKSP;
      keep       = 1'b1;
    end else if (key_char_i >= cle_pkg::PrintableMin) begin
      keep       = 1'b1;
    end
  end

  assign in_stall_o  = (fill_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = cmd_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    fill_d   = fill_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q] <= new_cmd;
    end
  end

endmodule

// ===== design/cle_back.sv =====
// ----------------------------------------------------------------------------
// cle_back
// Command executor: line buffer, character count, result sequencer and
// output register.
// ----------------------------------------------------------------------------
module cle_back #(
  parameter int unsigned LINE_CAP = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  cle_pkg::cle_cmd_t              cmd_i,
  output logic                           cmd_pop_o,
  input  logic [$clog2(LINE_CAP)-1:0]    limit_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     kind_o,
  output logic [cle_pkg::CharW-1:0]      char_value_o,
  output logic [cle_pkg::LenW-1:0]       line_length_o,
  output logic                           last_o
);

  localparam int unsigned CntW = $clog2(LINE_CAP);

  cle_pkg::cle_state_e state_q, state_d;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     idx_q;
  logic [CntW-1:0]     len_q;
  logic [cle_pkg::CharW-1:0] ch_q;

  logic                      out_valid_q;
  logic [1:0]                kind_q;
  logic [cle_pkg::CharW-1:0] char_q;
  logic [cle_pkg::LenW-1:0]  len_out_q;
  logic                      last_q;

  logic                      out_free;
  logic                      emit;
  cle_pkg::cle_kind_e        emit_kind;
  logic [cle_pkg::CharW-1:0] emit_char;
  logic [cle_pkg::LenW-1:0]  emit_len;
  logic                      emit_last;
  logic                      ram_we;
  logic                      ram_re;
  logic [cle_pkg::CharW-1:0] ram_rdata;
  logic                      print_ok;

  assign out_free = !out_valid_q || !out_stall_i;
  assign print_ok = (count_q < limit_i);

  cle_ram #(
    .WIDTH (cle_pkg::CharW),
    .DEPTH (LINE_CAP)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q),
    .wdata_i (cmd_i.ch),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cle_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            cle_pkg::OP_PRINT: state_d = print_ok ? cle_pkg::ST_ECHO : cle_pkg::ST_IDLE;
            cle_pkg::OP_BKSP:  state_d = (count_q != '0) ? cle_pkg::ST_BS1 : cle_pkg::ST_IDLE;
            cle_pkg::OP_ENTER: state_d = (count_q == '0) ? cle_pkg::ST_END
                                                         : cle_pkg::ST_DRAIN_RD;
            default:           state_d = cle_pkg::ST_IDLE;
          endcase
        end
      end
      cle_pkg::ST_ECHO: if (out_free) state_d = cle_pkg::ST_IDLE;
      cle_pkg::ST_BS1:  if (out_free) state_d = cle_pkg::ST_BS2;
      cle_pkg::ST_BS2:  if (out_free) state_d = cle_pkg::ST_BS3;
      cle_pkg::ST_BS3:  if (out_free) state_d = cle_pkg::ST_IDLE;
      cle_pkg::ST_DRAIN_RD: state_d = cle_pkg::ST_DRAIN_WR;
      cle_pkg::ST_DRAIN_WR: begin
        if (out_free) begin
          state_d = (idx_q == len_q - 1'b1) ? cle_pkg::ST_END : cle_pkg::ST_DRAIN_RD;
        end
      end
      cle_pkg::ST_END: if (out_free) state_d = cle_pkg::ST_IDLE;
      default: state_d = cle_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    emit      = 1'b0;
    emit_kind = cle_pkg::KIND_ECHO;
    emit_char = '0;
    emit_len  = '0;
    emit_last = 1'b0;
    case (state_q)
      cle_pkg::ST_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        ram_we    = cmd_valid_i && (cmd_i.op == cle_pkg::OP_PRINT) && print_ok;
      end
      cle_pkg::ST_ECHO: begin
        emit      = 1'b1;
        emit_char = ch_q;
        emit_last = 1'b1;
      end
      cle_pkg::ST_BS1: begin
        emit      = 1'b1;
        emit_char = cle_pkg::KeyBackspace;
      end
      cle_pkg::ST_BS2: begin
        emit      = 1'b1;
        emit_char = cle_pkg::KeySpace;
      end
      cle_pkg::ST_BS3: begin
        emit      = 1'b1;
        emit_char = cle_pkg::KeyBackspace;
        emit_last = 1'b1;
      end
      cle_pkg::ST_DRAIN_RD: begin
        ram_re = 1'b1;
      end
      cle_pkg::ST_DRAIN_WR: begin
        emit      = 1'b1;
        emit_kind = cle_pkg::KIND_LINE_CHAR;
        emit_char = ram_rdata;
      end
      cle_pkg::ST_END: begin
        emit      = 1'b1;
        emit_kind = cle_pkg::KIND_END;
        emit_len  = cle_pkg::LenW'(len_q);
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cle_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_free) begin
        out_valid_q <= emit;
      end
      if (state_q == cle_pkg::ST_IDLE && cmd_valid_i) begin
        case (cmd_i.op)
          cle_pkg::OP_PRINT: if (print_ok) count_q <= count_q + 1'b1;
          cle_pkg::OP_BKSP:  if (count_q != '0) count_q <= count_q - 1'b1;
          cle_pkg::OP_ENTER: begin
            len_q   <= count_q;
            count_q <= '0;
            idx_q   <= '0;
          end
          default: count_q <= count_q;
        endcase
      end
      if (state_q == cle_pkg::ST_DRAIN_WR && out_free) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cle_pkg::ST_IDLE && cmd_valid_i) begin
      ch_q <= cmd_i.ch;
    end
    if (out_free && emit) begin
      kind_q    <= emit_kind;
      char_q    <= emit_char;
      len_out_q <= emit_len;
      last_q    <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign char_value_o  = char_q;
  assign line_length_o = len_out_q;
  assign last_o        = last_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the console line editor.
// ----------------------------------------------------------------------------
// Keystrokes go in over the key stream. An in-bench line model predicts the
// echo, line-drain and end-of-line results for each accepted transfer, and
// every result transfer is checked field by field against the oldest
// prediction. A directed opening covers the empty-line, control-code, line-full
// and lowered-limit cases. Random typed lines follow under several line-length
// settings, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cle_pkg::cle_kind_e        kind;
    logic [cle_pkg::CharW-1:0] ch;
    logic [cle_pkg::LenW-1:0]  len;
    logic                      last;
  } echo_result_t;

  // Line model plus the queue of results it has promised.
  class line_echo_tracker;
    logic [cle_pkg::CharW-1:0] typed_chars[64];
    int unsigned               typed_count;
    logic [cle_pkg::CfgW-1:0]  max_line_len;
    echo_result_t              promised[$];
    int unsigned               errors;

    function new();
      typed_count  = 0;
      max_line_len = cle_pkg::MaxLineLenReset;
      errors       = 0;
    endfunction

    function void set_max_len(logic [cle_pkg::CfgW-1:0] v);
      max_line_len = v;
    endfunction

    // max_line_len - 1, clamped to 0 .. 63
    function int unsigned char_limit();
      if (max_line_len == 0) return 0;
      if (max_line_len - 1 > 63) return 63;
      return max_line_len - 1;
    endfunction

    // Returns how many results the key causes.
    function int take_key(logic [cle_pkg::CharW-1:0] key);
      int unsigned n;
      n = typed_count;
      if (key == cle_pkg::KeyEnter) begin
        for (int unsigned i = 0; i < n; i++)
          promised.push_back('{cle_pkg::KIND_LINE_CHAR, typed_chars[i], '0, 1'b0});
        promised.push_back('{cle_pkg::KIND_END, '0, cle_pkg::LenW'(n), 1'b1});
        typed_count = 0;
        return n + 1;
      end
      if (key == cle_pkg::KeyBackspace) begin
        if (n == 0) return 0;
        typed_count = n - 1;
        promised.push_back('{cle_pkg::KIND_ECHO, cle_pkg::KeyBackspace, '0, 1'b0});
        promised.push_back('{cle_pkg::KIND_ECHO, cle_pkg::KeySpace, '0, 1'b0});
        promised.push_back('{cle_pkg::KIND_ECHO, cle_pkg::KeyBackspace, '0, 1'b1});
        return 3;
      end
      if (key >= cle_pkg::PrintableMin && n < char_limit()) begin
        typed_chars[n] = key;
        typed_count = n + 1;
        promised.push_back('{cle_pkg::KIND_ECHO, key, '0, 1'b1});
        return 1;
      end
      return 0;
    endfunction

    function void check_output(logic [1:0] kind, logic [cle_pkg::CharW-1:0] ch,
                               logic [cle_pkg::LenW-1:0] len, logic last);
      echo_result_t want;
      if (promised.size() == 0) begin
        $display("%0t: result with none pending: kind %0d char %h len %0d last %0b",
                 $time, kind, ch, len, last);
        errors++;
        return;
      end
      want = promised.pop_front();
      if (kind !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
        errors++;
      end
      if (ch !== want.ch) begin
        $display("%0t: char_value expected %h actual %h", $time, want.ch, ch);
        errors++;
      end
      if (len !== want.len) begin
        $display("%0t: line_length expected %0d actual %0d", $time, want.len, len);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  // Cycles to let a busy block settle once all results are in: keys that
  // give no result may still sit in the command queue.
  localparam int SettleCycles = 32;
  localparam int TotalKeys    = 260;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [cle_pkg::CharW-1:0] key_char_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [1:0]                kind_o;
  logic [cle_pkg::CharW-1:0] char_value_o;
  logic [cle_pkg::LenW-1:0]  line_length_o;
  logic                      last_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [cle_pkg::CfgW-1:0]  cfg_wdata_i = '0;

  line_echo_tracker tracker = new();
  bit               steady_flow = 1'b0;  // both sides run without gaps
  int unsigned      sent_keys = 0;       // key transfers accepted so far

  console_line_editor uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_char_i    (key_char_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .char_value_o  (char_value_o),
    .line_length_o (line_length_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // Every result transfer is checked at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_output(kind_o, char_value_o, line_length_o, last_o);
  end

  // Result side: before each transfer, stall for a random hold (none in
  // steady flow), then hold stall low until the transfer happens.
  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 7);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // One key transfer after a random gap. Valid stays high when there is no
  // gap, so back-to-back keys never drop valid in between.
  task automatic send_key(input logic [cle_pkg::CharW-1:0] key);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_char_i <= key;
    do @(posedge clk_i); while (in_stall_o);
    void'(tracker.take_key(key));
    sent_keys++;
  endtask

  // Sender holds off until every promised result has arrived, then lets
  // queued swallowed keys drain out of the block.
  task automatic drain_line();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (tracker.promised.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Register write; only called right after drain_line.
  task automatic write_max_len(input logic [cle_pkg::CfgW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_max_len(v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [cle_pkg::CharW-1:0] random_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return cle_pkg::CharW'($urandom_range(16'h0020, 16'h007E));
    if (r < 70) return cle_pkg::CharW'($urandom_range(16'h0020, 16'hFFFF));
    if (r < 85) return cle_pkg::KeyBackspace;
    if (r < 92) return cle_pkg::CharW'($urandom_range(0, 16'h001F));  // control noise
    return cle_pkg::CharW'($urandom());
  endfunction

  // One typed line: mostly short, now and then long enough to fill the
  // buffer. Usually closed by enter; sometimes left open to run on.
  task automatic type_line();
    int unsigned len;
    len = ($urandom_range(0, 5) == 0) ? $urandom_range(55, 72) : $urandom_range(0, 12);
    repeat (len) send_key(random_key());
    if ($urandom_range(0, 9) != 0) send_key(cle_pkg::KeyEnter);
  endtask

  initial begin : stimulus
    logic [cle_pkg::CfgW-1:0] settings[9] = '{7'd64, 7'd127, 7'd2, 7'd40, 7'd0,
                                              7'd65, 7'd1, 7'd8, 7'd64};
    int unsigned phase;
    int unsigned goal;

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset length: empty-line enter, empty backspace, control codes,
    // printable extremes, one backspace, then a drained line.
    send_key(cle_pkg::KeyEnter);
    send_key(cle_pkg::KeyBackspace);
    send_key(16'h0000);
    send_key(16'h001F);
    send_key(cle_pkg::PrintableMin);
    send_key(16'hFFFF);
    send_key(16'h0041);
    send_key(16'h5AA5);
    send_key(cle_pkg::KeyBackspace);
    send_key(cle_pkg::KeyEnter);

    // Zero length stores nothing; enter gives a bare end marker.
    drain_line();
    write_max_len(7'd0);
    send_key(16'h0078);
    send_key(cle_pkg::KeyEnter);

    // Length 1 also leaves no room for a character.
    drain_line();
    write_max_len(7'd1);
    send_key(16'h0079);
    send_key(cle_pkg::KeyBackspace);
    send_key(cle_pkg::KeyEnter);

    // Oversized setting acts as the full buffer; type four characters,
    // then lower the limit under the count. Typing stays blocked until
    // backspaces bring the count under the new limit.
    drain_line();
    write_max_len(7'd127);
    repeat (4) send_key(cle_pkg::CharW'($urandom_range(16'h0020, 16'hFFFF)));
    drain_line();
    write_max_len(7'd3);
    send_key(16'h007A);
    send_key(cle_pkg::KeyBackspace);
    send_key(cle_pkg::KeyBackspace);
    send_key(16'h0071);
    send_key(cle_pkg::KeyBackspace);
    send_key(16'h0077);
    send_key(cle_pkg::KeyEnter);

    // Random lines, phase by phase over the length settings; some phases
    // run with no gaps and no stalls.
    phase = 0;
    while (sent_keys < TotalKeys) begin
      drain_line();
      write_max_len(settings[phase % 9]);
      steady_flow = (phase % 3 == 1);
      goal = sent_keys + 30;
      while (sent_keys < goal) type_line();
      phase++;
    end

    drain_line();
    if (tracker.errors == 0 && tracker.promised.size() == 0) begin
      $display("console_line_editor: match");
    end else begin
      $display("console_line_editor: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("console_line_editor: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
design/cle_pkg.sv
design/cle_ram.sv
design/cle_front.sv
design/cle_back.sv
design/console_line_editor.sv
tb/tb.sv
